/* design/ace_local_contrast_window_defines.svh */
// Assertion macros shared by the local contrast window design.
`ifndef ACE_LOCAL_CONTRAST_WINDOW_DEFINES_SVH
`define ACE_LOCAL_CONTRAST_WINDOW_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ACELCW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ACELCW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ACELCW_ASSERT_IMP(lbl, ante, cons, msg)
`define ACELCW_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* design/acelcw_pkg.sv */
// Types, constants and the weight table of the local contrast window.
package acelcw_pkg;

	localparam int WIN_R      = 2;
	localparam int SPAN       = 2 * WIN_R + 1;
	localparam int RING_ROWS  = 2 * WIN_R + 2;
	localparam int BANK_W     = $clog2(RING_ROWS);
	localparam int BOR_W      = $clog2(WIN_R + 1);
	localparam int PIX_W      = 8;
	localparam int CFG_W      = 11;
	localparam int GAIN_W     = 8;
	localparam int WGT_W      = 13;
	localparam int TERM_W     = 9;
	localparam int PROD_W     = TERM_W + WGT_W + 1;
	localparam int COLSUM_W   = PROD_W + 3;
	localparam int ACC_W      = COLSUM_W + 3;
	localparam int RES_W      = 17;
	localparam int FRAC_SHIFT = 8;
	localparam int OUT_LIMIT  = 65280;
	localparam int TERM_LIMIT = 255;
	localparam int CNT_W      = 3;
	localparam int CALC_LAST  = 3;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 4;

	// register indexes (byte address / 4)
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_WIDTH  = 2'd0;
	localparam reg_idx_t REG_HEIGHT = 2'd1;
	localparam reg_idx_t REG_GAIN   = 2'd2;

	localparam logic [CFG_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0]  HEIGHT_RST = 11'd480;
	localparam logic [GAIN_W-1:0] GAIN_RST   = 8'd4;

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CALC, ST_DONE} state_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             start_of_frame;
		logic             flush;
	} pix_in_t;

	typedef struct packed {
		logic signed [RES_W-1:0] contrast;
		logic                    last_of_frame;
	} res_out_t;

	typedef logic [SPAN-1:0][PIX_W-1:0] pix_col_t;
	typedef logic [SPAN-1:0][WGT_W-1:0] wgt_col_t;

	// 1/distance weights, normalized to 2^16, centre zero; symmetric in both axes
	localparam wgt_col_t WEIGHTS [SPAN] = '{
		'{13'd1677, 13'd2121, 13'd2371, 13'd2121, 13'd1677},
		'{13'd2121, 13'd3353, 13'd4742, 13'd3353, 13'd2121},
		'{13'd2371, 13'd4742, 13'd0,    13'd4742, 13'd2371},
		'{13'd2121, 13'd3353, 13'd4742, 13'd3353, 13'd2121},
		'{13'd1677, 13'd2121, 13'd2371, 13'd2121, 13'd1677}
	};

endpackage

/* design/ace_local_contrast_window.sv */
// Local contrast core: each pixel gets the weighted, clipped sum of its differences to the
// 5x5 neighborhood (zero padded), lagging the input by 2 rows plus 2 pixels; send that many
// flush items after a frame. A pixel that yields no result is only accepted. A pixel that
// yields a result is accepted, then its 5 columns are read from the row banks (each bank has
// one read port, so the window is gathered one column per cycle into the chain of column
// cells) and passed through the cell arithmetic; the result is loaded into the output register
// once that register is empty or being read, and no new pixel is taken until then.
`include "ace_local_contrast_window_defines.svh"
module ace_local_contrast_window import acelcw_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  pix_in_t           pix_data,
	output logic              res_valid,
	input  logic              res_ready,
	output res_out_t          res_data
);

	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int WEFF_W   = $clog2(MAX_WIDTH + 1);
	localparam int HEFF_W   = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_HOLD = MAX_HEIGHT + 2 * WIN_R + 2;
	localparam int ROW_W    = $clog2(ROW_HOLD + 1);
	localparam int WCMP_W   = (WEFF_W > CFG_W ? WEFF_W : CFG_W) + 1;
	localparam int HCMP_W   = (HEFF_W > CFG_W ? HEFF_W : CFG_W) + 1;
	localparam int SC_W     = WEFF_W + 2;
	localparam int SR_W     = ROW_W + 2;
	localparam int BT_W     = BANK_W + 2;

	logic [CFG_W-1:0]  width_q, height_q;
	logic [GAIN_W-1:0] gain_q;
	logic [WEFF_W-1:0] w_eff;
	logic [HEFF_W-1:0] h_eff;
	logic              cfg_wr;
	reg_idx_t          reg_idx;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              load_res;
	logic              pix_acc;

	logic [COL_W-1:0]  col_q, col_cur;
	logic [ROW_W-1:0]  row_q, row_cur;
	logic [BANK_W-1:0] ring_q, ring_cur;
	logic              sof_now, wrap_c;
	logic [SC_W-1:0]   qc_c;
	logic [SR_W-1:0]   qr_c, nr_c;
	logic [BOR_W-1:0]  borrow_c;
	logic [BT_W-1:0]   qbank_t;
	logic [BANK_W-1:0] qbank_c;
	logic [SPAN-1:0]   row_ok_c;
	logic              hit_c, last_c;

	logic [SC_W-1:0]   qc_q;
	logic [BANK_W-1:0] qbank_q;
	logic [SPAN-1:0]   row_ok_q;
	logic              last_q;

	logic [SC_W-1:0]   nc_c;
	logic              col_ok_c;
	logic              rd_vld_s1, col_ok_s1;
	logic [RING_ROWS-1:0][PIX_W-1:0] rdata;
	logic [BT_W-1:0]   bank_t;
	pix_col_t          col_new;
	pix_col_t          chain [SPAN];
	logic signed [COLSUM_W-1:0] sums [SPAN];
	logic signed [ACC_W-1:0]    total_c, shifted_c;
	logic signed [RES_W-1:0]    contrast_c;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			gain_q   <= GAIN_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				REG_GAIN:   gain_q   <= pwdata[GAIN_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = DATA_W'(width_q);
			REG_HEIGHT: prdata = DATA_W'(height_q);
			REG_GAIN:   prdata = DATA_W'(gain_q);
			default:    prdata = '0;
		endcase
	end

	// effective frame size: zero acts as one, oversize clips to the maximum
	always_comb begin
		if (width_q == '0) begin
			w_eff = WEFF_W'(1);
		end else if (WCMP_W'(width_q) > WCMP_W'(MAX_WIDTH)) begin
			w_eff = WEFF_W'(MAX_WIDTH);
		end else begin
			w_eff = WEFF_W'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HEFF_W'(1);
		end else if (HCMP_W'(height_q) > HCMP_W'(MAX_HEIGHT)) begin
			h_eff = HEFF_W'(MAX_HEIGHT);
		end else begin
			h_eff = HEFF_W'(height_q);
		end
	end

	// position of the incoming item and the window centre it completes
	always_comb begin
		sof_now  = !pix_data.flush && pix_data.start_of_frame;
		col_cur  = sof_now ? '0 : col_q;
		row_cur  = sof_now ? '0 : row_q;
		ring_cur = sof_now ? '0 : ring_q;

		qc_c     = SC_W'(col_cur) - SC_W'(WIN_R);
		borrow_c = '0;
		for (int i = 0; i < WIN_R; i++) begin
			if (qc_c[SC_W-1]) begin
				qc_c     = qc_c + SC_W'(w_eff);
				borrow_c = borrow_c + BOR_W'(1);
			end
		end
		qr_c  = SR_W'(row_cur) - SR_W'(WIN_R) - SR_W'(borrow_c);
		hit_c = (WEFF_W'(col_cur) < w_eff) && !qr_c[SR_W-1]
			&& (qr_c[SR_W-2:0] < (SR_W-1)'(h_eff));
		last_c = (qr_c[SR_W-2:0] == (SR_W-1)'(h_eff) - (SR_W-1)'(1))
			&& (qc_c[SC_W-2:0] == (SC_W-1)'(w_eff) - (SC_W-1)'(1));

		// ring bank holding the centre row
		qbank_t = BT_W'(ring_cur) - BT_W'(WIN_R) - BT_W'(borrow_c);
		if (qbank_t[BT_W-1]) begin
			qbank_t = qbank_t + BT_W'(RING_ROWS);
		end
		qbank_c = qbank_t[BANK_W-1:0];

		// window rows inside the frame
		for (int dy = 0; dy < SPAN; dy++) begin
			nr_c         = qr_c + SR_W'(dy) - SR_W'(WIN_R);
			row_ok_c[dy] = !nr_c[SR_W-1] && (nr_c[SR_W-2:0] < (SR_W-1)'(h_eff));
		end

		wrap_c = (WEFF_W + 1)'(col_cur) + (WEFF_W + 1)'(1) >= (WEFF_W + 1)'(w_eff);
	end

	assign pix_ready = (state_q == ST_IDLE);
	assign pix_acc   = pix_valid && pix_ready;

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ring_q <= '0;
		end else if (pix_acc) begin
			if (wrap_c) begin
				col_q <= '0;
				if (row_cur < ROW_W'(ROW_HOLD)) begin
					row_q  <= row_cur + ROW_W'(1);
					ring_q <= (ring_cur == BANK_W'(RING_ROWS - 1)) ? '0
						: ring_cur + BANK_W'(1);
				end else begin
					row_q  <= row_cur;
					ring_q <= ring_cur;
				end
			end else begin
				col_q  <= col_cur + COL_W'(1);
				row_q  <= row_cur;
				ring_q <= ring_cur;
			end
		end
	end

	// item context for the window gather
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			qc_q     <= qc_c;
			qbank_q  <= qbank_c;
			row_ok_q <= row_ok_c;
			last_q   <= last_c;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		load_res = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (pix_acc && hit_c) begin
					state_d = ST_READ;
					cnt_d   = '0;
				end
			end
			ST_READ: begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(SPAN - 1)) begin
					state_d = ST_CALC;
					cnt_d   = '0;
				end
			end
			ST_CALC: begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(CALC_LAST)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_valid || res_ready) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// window column address
	always_comb begin
		nc_c     = qc_q + SC_W'(cnt_q) - SC_W'(WIN_R);
		col_ok_c = !nc_c[SC_W-1] && (nc_c[SC_W-2:0] < (SC_W-1)'(w_eff));
	end

	acelcw_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
		.clk   (clk),
		.we    (pix_acc),
		.wbank (ring_cur),
		.waddr (col_cur),
		.wdata (pix_data.flush ? '0 : pix_data.pixel),
		.raddr (nc_c[COL_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_READ);
		end
	end

	always_ff @(posedge clk) begin
		col_ok_s1 <= col_ok_c;
	end

	// map banks to window rows, zero outside the frame
	always_comb begin
		for (int dy = 0; dy < SPAN; dy++) begin
			bank_t = BT_W'(qbank_q) + BT_W'(dy) - BT_W'(WIN_R);
			if (bank_t[BT_W-1]) begin
				bank_t = bank_t + BT_W'(RING_ROWS);
			end else if (bank_t >= BT_W'(RING_ROWS)) begin
				bank_t = bank_t - BT_W'(RING_ROWS);
			end
			col_new[dy] = (col_ok_s1 && row_ok_q[dy]) ? rdata[bank_t[BANK_W-1:0]] : '0;
		end
	end

	// chain of column cells
	for (genvar j = 0; j < SPAN; j++) begin : g_cell
		acelcw_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (rd_vld_s1),
			.col_in   ((j == 0) ? col_new : chain[(j == 0) ? 0 : j - 1]),
			.centre   (chain[WIN_R][WIN_R]),
			.gain     (gain_q),
			.wgt      (WEIGHTS[j]),
			.col_out  (chain[j]),
			.col_sum  (sums[j])
		);
	end

	// window total, scaling and saturation
	always_comb begin
		total_c = '0;
		for (int j = 0; j < SPAN; j++) begin
			total_c = total_c + ACC_W'(sums[j]);
		end
		shifted_c = total_c >>> FRAC_SHIFT;
		if (shifted_c > OUT_LIMIT) begin
			contrast_c = RES_W'(OUT_LIMIT);
		end else if (shifted_c < -OUT_LIMIT) begin
			contrast_c = -RES_W'(OUT_LIMIT);
		end else begin
			contrast_c = shifted_c[RES_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (load_res) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_data.contrast      <= contrast_c;
			res_data.last_of_frame <= last_q;
		end
	end

	`ACELCW_ASSERT_NXT(a_hit_starts_read, pix_acc && hit_c, state_q == ST_READ, "result pixel did not start the gather")
	`ACELCW_ASSERT_IMP(a_shift_in_gather, rd_vld_s1, state_q == ST_READ || state_q == ST_CALC, "window shift outside the gather")
	`ACELCW_ASSERT_NXT(a_done_loads, state_q == ST_DONE && (!res_valid || res_ready), res_valid && state_q == ST_IDLE, "finished result not transferred to output")

endmodule

/* design/acelcw_cell.sv */
// One window column cell: holds a column, passes it on, forms its weighted sum.
module acelcw_cell import acelcw_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift_en,
	input  pix_col_t                   col_in,
	input  logic [PIX_W-1:0]           centre,
	input  logic [GAIN_W-1:0]          gain,
	input  wgt_col_t                   wgt,
	output pix_col_t                   col_out,
	output logic signed [COLSUM_W-1:0] col_sum
);

	pix_col_t                         pix_q;
	logic signed [TERM_W-1:0]         term_c  [SPAN];
	logic signed [TERM_W-1:0]         term_s1 [SPAN];
	logic signed [PROD_W-1:0]         prod_s2 [SPAN];
	logic signed [COLSUM_W-1:0]       sum_c;
	logic signed [COLSUM_W-1:0]       col_sum_s3;
	logic signed [PIX_W:0]            diff    [SPAN];
	logic signed [PIX_W+GAIN_W+1:0]   scaled  [SPAN];

	// column shift register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (shift_en) begin
			pix_q <= col_in;
		end
	end

	assign col_out = pix_q;

	// gain times difference, clipped to +/-255
	always_comb begin
		for (int i = 0; i < SPAN; i++) begin
			diff[i]   = $signed({1'b0, centre}) - $signed({1'b0, pix_q[i]});
			scaled[i] = $signed({1'b0, gain}) * diff[i];
			if (scaled[i] > TERM_LIMIT) begin
				term_c[i] = TERM_W'(TERM_LIMIT);
			end else if (scaled[i] < -TERM_LIMIT) begin
				term_c[i] = -TERM_W'(TERM_LIMIT);
			end else begin
				term_c[i] = scaled[i][TERM_W-1:0];
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < SPAN; i++) begin
			sum_c = sum_c + COLSUM_W'(prod_s2[i]);
		end
	end

	// term, weighted product, column sum
	always_ff @(posedge clk) begin
		for (int i = 0; i < SPAN; i++) begin
			term_s1[i] <= term_c[i];
			prod_s2[i] <= term_s1[i] * $signed({1'b0, wgt[i]});
		end
		col_sum_s3 <= sum_c;
	end

	assign col_sum = col_sum_s3;

endmodule

/* design/acelcw_line_store.sv */
// Ring of row banks: one write port, all banks read at one column each cycle.
module acelcw_line_store import acelcw_pkg::*; #(
	parameter  int MAX_WIDTH = 1024,
	localparam int COL_W     = $clog2(MAX_WIDTH)
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [BANK_W-1:0]                wbank,
	input  logic [COL_W-1:0]                 waddr,
	input  logic [PIX_W-1:0]                 wdata,
	input  logic [COL_W-1:0]                 raddr,
	output logic [RING_ROWS-1:0][PIX_W-1:0]  rdata
);

	for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
		logic [PIX_W-1:0] mem [MAX_WIDTH];
		logic [PIX_W-1:0] rd_q;

		always_ff @(posedge clk) begin
			if (we && wbank == BANK_W'(b)) begin
				mem[waddr] <= wdata;
			end
			rd_q <= mem[raddr];
		end

		assign rdata[b] = rd_q;
	end

endmodule
